/* rtl/core/mrot90_pkg.sv */
// Shared types and constants for the 90-degree clockwise matrix rotator.
package mrot90_pkg;

	localparam int DATA_W = 32;
	localparam int SIDE_W = 4;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [SIDE_W-1:0]        side_t;

	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_READ = 2'b10
	} phase_t;

endpackage

/* rtl/core/matrix_rotate_90_clockwise.sv */
// Rotator top level: element store, load and read-out sequencing, output register.
// Load: one element beat per cycle, written straight into the element store.
// Read-out starts the cycle after the last element: n*n store reads, one per unstalled cycle,
// through the registered read port and the output register; loading resumes after the last read.
// No element is accepted during read-out, so the load and read-out of a matrix never overlap.
// Reset clears control and sets the side to 8; store contents are undefined until written.
module matrix_rotate_90_clockwise #(
	parameter int MAX_SIDE = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 side_wr_en,
	input  mrot90_pkg::side_t    matrix_side,
	input  logic                 element_valid,
	output logic                 element_ready,
	input  mrot90_pkg::data_t    element_value,
	output logic                 rotated_valid,
	input  logic                 rotated_ready,
	output mrot90_pkg::data_t    rotated_value,
	output logic                 row_end,
	output logic                 matrix_last
);

	import mrot90_pkg::*;

	localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
	localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam side_t MAX_SIDE_C = SIDE_W'(MAX_SIDE);

	phase_t            state_q;
	side_t             side_q;
	side_t             side_act;
	logic [IDX_W-1:0]  n_last;
	logic [IDX_W-1:0]  ld_row_q, ld_col_q;
	logic [IDX_W-1:0]  rd_row_q, rd_col_q;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic              wr_en, rd_en;
	logic              rd_valid_s1, row_end_s1, last_s1;
	data_t             rd_data_s1;
	logic              s1_move;
	logic              ld_col_end, rd_col_end;
	data_t             mem [DEPTH];

	always_comb begin
		side_act = side_q;
		if (side_q == '0) begin
			side_act = side_t'(1);
		end else if (side_q > MAX_SIDE_C) begin
			side_act = MAX_SIDE_C;
		end
	end

	assign n_last = IDX_W'(side_act - side_t'(1));

	assign element_ready = (state_q == ST_LOAD);
	assign wr_en         = element_valid && element_ready;
	assign s1_move       = rd_valid_s1 && (!rotated_valid || rotated_ready);
	assign rd_en         = (state_q == ST_READ) && (!rd_valid_s1 || s1_move);

	assign ld_col_end = (ld_col_q == n_last);
	assign rd_col_end = (rd_col_q == n_last);

	assign wr_addr = ADDR_W'(ADDR_W'(ld_row_q) * ADDR_W'(MAX_SIDE) + ADDR_W'(ld_col_q));
	assign rd_addr = ADDR_W'(ADDR_W'(n_last - rd_col_q) * ADDR_W'(MAX_SIDE) + ADDR_W'(rd_row_q));

	// element store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= element_value;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			row_end_s1 <= rd_col_end;
			last_s1    <= rd_col_end && (rd_row_q == n_last);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			side_q   <= side_t'(8);
			ld_row_q <= '0;
			ld_col_q <= '0;
			rd_row_q <= '0;
			rd_col_q <= '0;
		end else begin
			if (side_wr_en) begin
				side_q   <= matrix_side;
				ld_row_q <= '0;
				ld_col_q <= '0;
			end else if (wr_en) begin
				if (ld_col_end) begin
					ld_col_q <= '0;
					if (ld_row_q == n_last) begin
						ld_row_q <= '0;
						state_q  <= ST_READ;
					end else begin
						ld_row_q <= ld_row_q + 1'b1;
					end
				end else begin
					ld_col_q <= ld_col_q + 1'b1;
				end
			end
			if (rd_en) begin
				if (rd_col_end) begin
					rd_col_q <= '0;
					if (rd_row_q == n_last) begin
						rd_row_q <= '0;
						state_q  <= ST_LOAD;
					end else begin
						rd_row_q <= rd_row_q + 1'b1;
					end
				end else begin
					rd_col_q <= rd_col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1   <= 1'b0;
			rotated_valid <= 1'b0;
		end else begin
			if (rd_en) begin
				rd_valid_s1 <= 1'b1;
			end else if (s1_move) begin
				rd_valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				rotated_valid <= 1'b1;
			end else if (rotated_ready) begin
				rotated_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			rotated_value <= rd_data_s1;
			row_end       <= row_end_s1;
			matrix_last   <= last_s1;
		end
	end

	a_no_s1_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 && !s1_move |-> !rd_en)
		else $error("read data overwritten while stalled");

	a_last_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		rotated_valid && matrix_last |-> row_end)
		else $error("matrix end beat does not end a row");

	a_load_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ld_row_q <= n_last && ld_col_q <= n_last)
		else $error("load position outside matrix");

	a_read_done_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && rd_col_end && rd_row_q == n_last |=> state_q == ST_LOAD)
		else $error("read-out did not return to load");

endmodule

/* dv/matrix_rotate_90_clockwise_test.sv */
// Self-checking testbench for the 90-degree clockwise matrix rotator.
module matrix_rotate_90_clockwise_test;
	import mrot90_pkg::*;

	localparam int MAX_SIDE  = 8;
	localparam int CYC_LIMIT = 150000;

	typedef struct packed {
		data_t value;
		logic  row_end;
		logic  last;
	} rot_beat_t;

	typedef enum logic {ROW_SIDE, ROW_ELEM} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] arg;
		logic        typed;
		rot_beat_t   want;
	} dir_row_t;

	logic  clk           = 1'b0;
	logic  arst_n        = 1'b0;
	logic  side_wr_en    = 1'b0;
	side_t matrix_side   = side_t'(8);
	logic  element_valid = 1'b0;
	logic  element_ready;
	data_t element_value = '0;
	logic  rotated_valid;
	logic  rotated_ready = 1'b0;
	data_t rotated_value;
	logic  row_end;
	logic  matrix_last;

	matrix_rotate_90_clockwise #(.MAX_SIDE(MAX_SIDE)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.side_wr_en(side_wr_en),
		.matrix_side(matrix_side),
		.element_valid(element_valid),
		.element_ready(element_ready),
		.element_value(element_value),
		.rotated_valid(rotated_valid),
		.rotated_ready(rotated_ready),
		.rotated_value(rotated_value),
		.row_end(row_end),
		.matrix_last(matrix_last)
	);

	// shadow of the block
	data_t     shadow_store [MAX_SIDE*MAX_SIDE];
	side_t     side_reg = side_t'(8);
	int        fill_count = 0;
	rot_beat_t rotated_beats [$];
	rot_beat_t pending_rotated [$];

	int        error_count = 0;
	int        cycle_count = 0;
	int        burst_left = 0;
	bit        steady = 0;
	logic [15:0] ready_mask = '1;
	int        mask_pos = 0;
	rot_beat_t got_want;

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYC_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int side_in_use(input side_t s);
		if (s == 0)
			return 1;
		if (s > MAX_SIDE)
			return MAX_SIDE;
		return int'(s);
	endfunction

	// loads one element; a completed matrix leaves its rotation in rotated_beats
	task automatic load_and_rotate(input data_t v);
		int n;
		int total;
		int src;
		n = side_in_use(side_reg);
		total = n * n;
		rotated_beats.delete();
		if (fill_count >= total)
			fill_count = 0;
		shadow_store[fill_count % (MAX_SIDE*MAX_SIDE)] = v;
		fill_count = (fill_count + 1) & 7'h7f;
		if (fill_count < total)
			return;
		for (int r = 0; r < n; r++) begin
			for (int c = 0; c < n; c++) begin
				src = (n - 1 - c) * n + r;
				rotated_beats.push_back('{shadow_store[src], c == n - 1,
					r == n - 1 && c == n - 1});
			end
		end
		fill_count = 0;
	endtask

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("%s", msg);
	endtask

	task automatic write_side(input side_t s);
		element_valid <= 1'b0;
		while (pending_rotated.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		side_wr_en  <= 1'b1;
		matrix_side <= s;
		@(posedge clk);
		side_wr_en <= 1'b0;
		side_reg   = s;
		fill_count = 0;
	endtask

	task automatic send_element(input data_t v, input logic typed, input rot_beat_t want);
		int gap;
		if (!steady && burst_left == 0) begin
			gap        = $urandom_range(1, 6);
			burst_left = $urandom_range(1, 12);
			element_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		element_valid <= 1'b1;
		element_value <= v;
		do
			@(posedge clk);
		while (!element_ready);
		load_and_rotate(v);
		if (typed)
			pending_rotated.push_back(want);
		else
			foreach (rotated_beats[i])
				pending_rotated.push_back(rotated_beats[i]);
	endtask

	function automatic data_t rand_element();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random(input int count);
		for (int i = 0; i < count; i++)
			send_element(rand_element(), 1'b0, '0);
	endtask

	// result side: check each beat, then stall on a mask of its own
	always @(posedge clk) begin
		if (arst_n && rotated_valid && rotated_ready) begin
			if (pending_rotated.size() == 0) begin
				note_error($sformatf("unexpected beat: value %h row_end %b last %b",
					rotated_value, row_end, matrix_last));
			end else begin
				got_want = pending_rotated.pop_front();
				if (rotated_value !== got_want.value || row_end !== got_want.row_end ||
						matrix_last !== got_want.last)
					note_error($sformatf(
						"mismatch exp/got: value %h/%h row_end %b/%b last %b/%b",
						got_want.value, rotated_value, got_want.row_end, row_end,
						got_want.last, matrix_last));
			end
		end
		if (mask_pos == 0) begin
			case ($urandom_range(0, 3))
				0: ready_mask = '1;
				1: ready_mask = $urandom;
				2: ready_mask = $urandom | $urandom;
				default: ready_mask = 16'haaaa;
			endcase
		end
		rotated_ready <= ready_mask[mask_pos];
		mask_pos = (mask_pos + 1) % 16;
	end

	initial begin
		dir_row_t dir_rows [$];
		int       rand_sent;
		int       n;
		int       mats;
		int       part;
		int       pick;
		side_t    s;

		// side 8 from reset, partial load, dropped by the side write
		dir_rows.push_back('{ROW_ELEM, 32'h7fffffff, 1'b0, '0});
		dir_rows.push_back('{ROW_ELEM, 32'h80000000, 1'b0, '0});
		dir_rows.push_back('{ROW_ELEM, 32'hffffffff, 1'b0, '0});
		dir_rows.push_back('{ROW_SIDE, 32'd1, 1'b0, '0});
		dir_rows.push_back('{ROW_ELEM, 32'h7fffffff, 1'b1, '{32'h7fffffff, 1'b1, 1'b1}});
		dir_rows.push_back('{ROW_ELEM, 32'h80000000, 1'b1, '{32'h80000000, 1'b1, 1'b1}});
		dir_rows.push_back('{ROW_ELEM, 32'h00000000, 1'b1, '{32'h00000000, 1'b1, 1'b1}});
		dir_rows.push_back('{ROW_ELEM, 32'hffffffff, 1'b1, '{32'hffffffff, 1'b1, 1'b1}});
		// side zero behaves as side one
		dir_rows.push_back('{ROW_SIDE, 32'd0, 1'b0, '0});
		dir_rows.push_back('{ROW_ELEM, 32'h12345678, 1'b1, '{32'h12345678, 1'b1, 1'b1}});
		dir_rows.push_back('{ROW_SIDE, 32'd2, 1'b0, '0});
		dir_rows.push_back('{ROW_ELEM, 32'd1, 1'b0, '0});
		dir_rows.push_back('{ROW_ELEM, 32'd2, 1'b0, '0});
		dir_rows.push_back('{ROW_ELEM, 32'd3, 1'b0, '0});
		dir_rows.push_back('{ROW_ELEM, 32'd4, 1'b0, '0});
		// oversize side clamps to eight; dropped after two elements
		dir_rows.push_back('{ROW_SIDE, 32'd15, 1'b0, '0});
		dir_rows.push_back('{ROW_ELEM, 32'h5a5a5a5a, 1'b0, '0});
		dir_rows.push_back('{ROW_ELEM, 32'ha5a5a5a5, 1'b0, '0});
		dir_rows.push_back('{ROW_SIDE, 32'd3, 1'b0, '0});
		for (int i = 0; i < 9; i++)
			dir_rows.push_back('{ROW_ELEM, 32'h80000001 + 32'h11111111 * i, 1'b0, '0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_SIDE)
				write_side(side_t'(dir_rows[i].arg));
			else
				send_element(dir_rows[i].arg, dir_rows[i].typed, dir_rows[i].want);
		end

		// one full-size matrix, then mostly small ones
		write_side(side_t'(8));
		send_random(64);
		rand_sent = 64;
		while (rand_sent < 105) begin
			pick = $urandom_range(0, 15);
			if (pick == 0)
				s = side_t'(0);
			else if (pick == 1)
				s = side_t'($urandom_range(9, 15));
			else if (pick == 2)
				s = side_t'(8);
			else if (pick < 6)
				s = side_t'($urandom_range(5, 7));
			else
				s = side_t'($urandom_range(1, 4));
			write_side(s);
			n      = side_in_use(s);
			steady = ($urandom_range(0, 3) == 0);
			mats   = $urandom_range(1, 3);
			for (int m = 0; m < mats; m++) begin
				if (rand_sent + n * n > 115)
					break;
				if (n > 1 && $urandom_range(0, 5) == 0) begin
					// broken matrix: the next side write drops it
					part = $urandom_range(1, n * n - 1);
					send_random(part);
					rand_sent += part;
					break;
				end
				send_random(n * n);
				rand_sent += n * n;
			end
		end

		element_valid <= 1'b0;
		while (pending_rotated.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
